// ===== rtl/core/assert_macros.svh =====
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property checked at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Property checked at every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ===== rtl/core/cmoc_pkg.sv =====
`timescale 1ns / 1ps
package cmoc_pkg;

   // Item kinds carried in the func field.
   localparam logic [1:0] FUNC_PIXEL     = 2'd0;
   localparam logic [1:0] FUNC_BG_LOAD   = 2'd1;
   localparam logic [1:0] FUNC_OVER_LOAD = 2'd2;

   // Configuration register indexes.
   localparam logic [2:0] REG_MODE       = 3'd0;
   localparam logic [2:0] REG_BG_LOW     = 3'd1;
   localparam logic [2:0] REG_BG_HIGH    = 3'd2;
   localparam logic [2:0] REG_OVER_LOW   = 3'd3;
   localparam logic [2:0] REG_OVER_HIGH  = 3'd4;
   localparam logic [2:0] REG_ALPHA_LOW  = 3'd5;
   localparam logic [2:0] REG_ALPHA_HIGH = 3'd6;
   localparam logic [2:0] REG_ALPHA_KNEE = 3'd7;

   // Threshold band kinds; modes at or above the blend base blend.
   localparam logic [2:0] KIND_ABOVE      = 3'd1;
   localparam logic [2:0] KIND_BELOW      = 3'd2;
   localparam logic [2:0] MODE_BLEND_BASE = 3'd3;

   // Reset values of the configuration registers.
   localparam logic [2:0]        RST_MODE       = 3'd0;
   localparam logic signed [23:0] RST_BG_LOW    = 24'sd0;
   localparam logic signed [23:0] RST_BG_HIGH   = 24'sd1044480;
   localparam logic signed [23:0] RST_OVER_LOW  = 24'sd0;
   localparam logic signed [23:0] RST_OVER_HIGH = 24'sd2048;
   localparam logic [12:0]       RST_ALPHA_LOW  = 13'd0;
   localparam logic [12:0]       RST_ALPHA_HIGH = 13'd4096;
   localparam logic signed [23:0] RST_KNEE      = 24'sd0;

   localparam logic [12:0] ALPHA_ONE = 13'd4096;
   localparam logic [7:0]  COLOR_MAX = 8'd255;

   // Quotient bits produced by each divider.
   localparam int QUOT_W = 13;

   // Result queue sizing.
   localparam int RSP_FIFO_DEPTH = 32;
   localparam int RSP_PTR_W      = 5;
   localparam int RSP_CNT_W      = 6;

   typedef struct packed {
      logic [1:0]         func;
      logic signed [23:0] bg_value;
      logic signed [23:0] over_value;
      logic [7:0]         palette_index;
      logic [7:0]         palette_red;
      logic [7:0]         palette_green;
      logic [7:0]         palette_blue;
   } req_word_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       overlay_shown;
   } rsp_word_type;

endpackage

// ===== rtl/core/cmoc_divider.sv =====
`timescale 1ns / 1ps
module cmoc_divider #(
   parameter int NUM_W = 34,
   parameter int DEN_W = 26,
   parameter int QUO_W = 13
) (
   input  logic             clock,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic [QUO_W-1:0] quotient,
   output logic             saturated
);
   localparam int REM_W = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

   logic [REM_W-1:0] rem_ff [QUO_W];
   logic [DEN_W-1:0] den_ff [QUO_W];
   logic [QUO_W-1:0] quo_ff [QUO_W+1];
   logic             sat_ff [QUO_W+1];

   // First stage flags quotients that do not fit in QUO_W bits.
   always_ff @(posedge clock) begin
      rem_ff[0] <= REM_W'(num);
      den_ff[0] <= den;
      quo_ff[0] <= '0;
      sat_ff[0] <= REM_W'(num) >= (REM_W'(den) << QUO_W);
   end

   // One restoring step per stage, most significant quotient bit first.
   for (genvar k = 1; k <= QUO_W; k++) begin : g_step
      logic [REM_W-1:0] trial;
      logic             take;

      assign trial = REM_W'(den_ff[k-1]) << (QUO_W - k);
      assign take  = rem_ff[k-1] >= trial;

      always_ff @(posedge clock) begin
         quo_ff[k] <= quo_ff[k-1] | (take ? (QUO_W'(1) << (QUO_W - k)) : QUO_W'(0));
         sat_ff[k] <= sat_ff[k-1];
      end

      if (k < QUO_W) begin : g_carry
         always_ff @(posedge clock) begin
            rem_ff[k] <= take ? rem_ff[k-1] - trial : rem_ff[k-1];
            den_ff[k] <= den_ff[k-1];
         end
      end
   end

   assign quotient  = quo_ff[QUO_W];
   assign saturated = sat_ff[QUO_W];

endmodule

// ===== rtl/core/colormap_overlay_compositor.sv =====
`timescale 1ns / 1ps
// Window/level colormap compositor with a thresholded overlay.
// Request channel (req_): one word per item. A pixel word carries a background and
// an overlay sample and yields exactly one response word; a palette load word
// writes one entry of the background or overlay palette and yields nothing.
// Response channel (rsp_): the composited color and the overlay_shown flag, in
// request order. Configuration channel (csr_): always ready, one register write
// per cycle; the user must see that it is written only while the block is idle;
// the block itself does not enforce this. Throughput: one request word per clock
// while req_ready is high. A pixel accepted at a clock edge passes in turn through
// the accepted-word register, two setup stages, the three long dividers (a range
// stage plus 13 quotient stages), the palette memory read and the blend multiply,
// and is then written into the response queue. Each palette is a single
// synchronous memory; loads and pixel reads reach it at the same stage and in
// request order, so no forwarding is needed.
// A 32-word response queue sits at the output. A pixel is accepted only while a
// queue slot is reserved for it, so a stalled receiver does not stop the pipeline;
// the request side stalls once 32 pixel responses are outstanding.
// Synchronous reset clears the pipeline, the queue and the configuration
// registers. Palette contents are undefined until loaded.
module colormap_overlay_compositor #(
   parameter int PALETTE_DEPTH = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  cmoc_pkg::req_word_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output cmoc_pkg::rsp_word_type rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [2:0]            csr_index,
   input  logic [23:0]           csr_wdata
);
   import cmoc_pkg::*;

   localparam int PAL_AW  = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
   localparam int DIV_LAT = QUOT_W + 1;

   typedef struct packed {
      logic [1:0]         func;
      logic [7:0]         pal_index;
      logic [23:0]        pal_rgb;
      logic               b_lo;
      logic               b_hi;
      logic signed [32:0] b_num255;
      logic signed [24:0] b_span;
      logic signed [32:0] o_num255;
      logic signed [24:0] o_span;
      logic               ov_gt_olo;
      logic               shown;
      logic               blend;
      logic               a_const;
      logic signed [38:0] a_prod;
      logic signed [24:0] k_span;
      logic [12:0]        a_high;
   } p2_type;

   typedef struct packed {
      logic [1:0]  func;
      logic [7:0]  pal_index;
      logic [23:0] pal_rgb;
      logic        b_lo;
      logic        b_hi;
      logic        o_empty;
      logic        ov_gt_olo;
      logic        o_neg;
      logic        shown;
      logic        blend;
      logic        a_const;
      logic        a_negq;
      logic [12:0] a_high;
   } side_type;

   // ------------------------------------------------------------------
   // Configuration registers.
   // ------------------------------------------------------------------
   logic [2:0]         mode_ff;
   logic signed [23:0] bg_low_ff, bg_high_ff, over_low_ff, over_high_ff, knee_ff;
   logic [12:0]        alpha_low_ff, alpha_high_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= RST_MODE;
         bg_low_ff     <= RST_BG_LOW;
         bg_high_ff    <= RST_BG_HIGH;
         over_low_ff   <= RST_OVER_LOW;
         over_high_ff  <= RST_OVER_HIGH;
         alpha_low_ff  <= RST_ALPHA_LOW;
         alpha_high_ff <= RST_ALPHA_HIGH;
         knee_ff       <= RST_KNEE;
      end else if (csr_valid) begin
         case (csr_index)
            REG_MODE:       mode_ff       <= csr_wdata[2:0];
            REG_BG_LOW:     bg_low_ff     <= csr_wdata;
            REG_BG_HIGH:    bg_high_ff    <= csr_wdata;
            REG_OVER_LOW:   over_low_ff   <= csr_wdata;
            REG_OVER_HIGH:  over_high_ff  <= csr_wdata;
            REG_ALPHA_LOW:  alpha_low_ff  <= csr_wdata[12:0];
            REG_ALPHA_HIGH: alpha_high_ff <= csr_wdata[12:0];
            REG_ALPHA_KNEE: knee_ff       <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Credits: pixels accepted whose response word has not been taken yet.
   // Keeping this at or below the queue depth means the queue never overflows.
   // ------------------------------------------------------------------
   logic [RSP_CNT_W-1:0] credit_ff, credit_in;
   logic                 req_take, pix_take, rsp_pop;

   assign req_ready = credit_ff < RSP_CNT_W'(RSP_FIFO_DEPTH);
   assign req_take  = req_valid && req_ready;
   assign pix_take  = req_take && (req_data.func == FUNC_PIXEL);
   assign rsp_pop   = rsp_valid && rsp_ready;

   always_comb begin
      credit_in = credit_ff;
      if (pix_take && !rsp_pop) begin
         credit_in = credit_ff + RSP_CNT_W'(1);
      end else if (!pix_take && rsp_pop) begin
         credit_in = credit_ff - RSP_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff <= '0;
      end else begin
         credit_ff <= credit_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 1: the accepted word.
   // ------------------------------------------------------------------
   logic         p1_valid_ff;
   req_word_type p1_word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff <= req_take;
      end
      p1_word_ff <= req_data;
   end

   // Window differences, band decision and the alpha ramp product.
   logic signed [24:0] s1_bdiff, s1_odiff, s1_kdiff;
   logic signed [13:0] s1_adelta;
   logic               s1_blend;
   logic [2:0]         s1_kind;
   p2_type             p2_in, p2_ff;
   logic               p2_valid_ff;

   always_comb begin
      s1_bdiff  = 25'(p1_word_ff.bg_value) - 25'(bg_low_ff);
      s1_odiff  = 25'(p1_word_ff.over_value) - 25'(over_low_ff);
      s1_kdiff  = 25'(p1_word_ff.over_value) - 25'(knee_ff);
      s1_adelta = $signed({1'b0, alpha_high_ff}) - $signed({1'b0, alpha_low_ff});
      s1_blend  = mode_ff >= MODE_BLEND_BASE;
      s1_kind   = s1_blend ? mode_ff - MODE_BLEND_BASE : mode_ff;

      p2_in.func      = p1_word_ff.func;
      p2_in.pal_index = p1_word_ff.palette_index;
      p2_in.pal_rgb   = {p1_word_ff.palette_red, p1_word_ff.palette_green,
                         p1_word_ff.palette_blue};
      p2_in.b_lo      = p1_word_ff.bg_value <= bg_low_ff;
      p2_in.b_hi      = p1_word_ff.bg_value >= bg_high_ff;
      p2_in.b_num255  = (33'(s1_bdiff) <<< 8) - 33'(s1_bdiff);
      p2_in.b_span    = 25'(bg_high_ff) - 25'(bg_low_ff);
      p2_in.o_num255  = (33'(s1_odiff) <<< 8) - 33'(s1_odiff);
      p2_in.o_span    = 25'(over_high_ff) - 25'(over_low_ff);
      p2_in.ov_gt_olo = p1_word_ff.over_value > over_low_ff;
      case (s1_kind)
         KIND_ABOVE: p2_in.shown = p1_word_ff.over_value >= over_low_ff;
         KIND_BELOW: p2_in.shown = p1_word_ff.over_value <= over_high_ff;
         default:    p2_in.shown = (p1_word_ff.over_value >= over_low_ff) &&
                                   (p1_word_ff.over_value <= over_high_ff);
      endcase
      p2_in.blend     = s1_blend;
      p2_in.k_span    = 25'(knee_ff) - 25'(over_high_ff);
      p2_in.a_const   = (p1_word_ff.over_value < knee_ff) || (p2_in.k_span == '0);
      p2_in.a_prod    = 39'(s1_adelta) * 39'(s1_kdiff);
      p2_in.a_high    = alpha_high_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_valid_ff <= 1'b0;
      end else begin
         p2_valid_ff <= p1_valid_ff;
      end
      p2_ff <= p2_in;
   end

   // ------------------------------------------------------------------
   // Stage 2: sign-normalized dividends and divisors for the three divides.
   // Negative alpha quotients are floored by dividing |num| + den - 1.
   // ------------------------------------------------------------------
   logic signed [33:0] s2_on;
   logic signed [25:0] s2_od;
   logic signed [35:0] s2_ov2;
   logic signed [39:0] s2_an;
   logic signed [24:0] s2_ak;
   logic [39:0]        s2_adiv;
   logic [32:0]        p3_bnum_ff;
   logic [25:0]        p3_bden_ff;
   logic [33:0]        p3_onum_ff;
   logic [25:0]        p3_oden_ff;
   logic [38:0]        p3_anum_ff;
   logic [23:0]        p3_aden_ff;
   side_type           p3_side_in, p3_side_ff;
   logic               p3_valid_ff;

   always_comb begin
      s2_on   = p2_ff.o_span[24] ? -34'(p2_ff.o_num255) : 34'(p2_ff.o_num255);
      s2_od   = p2_ff.o_span[24] ? -26'(p2_ff.o_span) : 26'(p2_ff.o_span);
      s2_ov2  = (36'(s2_on) <<< 1) + 36'(s2_od);
      s2_an   = p2_ff.k_span[24] ? -40'(p2_ff.a_prod) : 40'(p2_ff.a_prod);
      s2_ak   = p2_ff.k_span[24] ? -p2_ff.k_span : p2_ff.k_span;
      s2_adiv = s2_an[39] ? 40'(-s2_an) + 40'(s2_ak[23:0]) - 40'd1 : 40'(s2_an);

      p3_side_in.func      = p2_ff.func;
      p3_side_in.pal_index = p2_ff.pal_index;
      p3_side_in.pal_rgb   = p2_ff.pal_rgb;
      p3_side_in.b_lo      = p2_ff.b_lo;
      p3_side_in.b_hi      = p2_ff.b_hi;
      p3_side_in.o_empty   = p2_ff.o_span == '0;
      p3_side_in.ov_gt_olo = p2_ff.ov_gt_olo;
      p3_side_in.o_neg     = s2_ov2[35];
      p3_side_in.shown     = p2_ff.shown;
      p3_side_in.blend     = p2_ff.blend;
      p3_side_in.a_const   = p2_ff.a_const;
      p3_side_in.a_negq    = s2_an[39];
      p3_side_in.a_high    = p2_ff.a_high;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p3_valid_ff <= 1'b0;
      end else begin
         p3_valid_ff <= p2_valid_ff;
      end
      p3_bnum_ff <= {p2_ff.b_num255[31:0], 1'b0} + 33'(p2_ff.b_span);
      p3_bden_ff <= {p2_ff.b_span, 1'b0};
      p3_onum_ff <= s2_ov2[33:0];
      p3_oden_ff <= {s2_od[24:0], 1'b0};
      p3_anum_ff <= s2_adiv[38:0];
      p3_aden_ff <= s2_ak[23:0];
      p3_side_ff <= p3_side_in;
   end

   // ------------------------------------------------------------------
   // Dividers and the matching sideband delay line.
   // ------------------------------------------------------------------
   logic [QUOT_W-1:0] b_quo, o_quo, a_quo;
   logic              b_sat, o_sat, a_sat;

   cmoc_divider #(.NUM_W(33), .DEN_W(26), .QUO_W(QUOT_W)) u_bg_div (
      .clock(clock), .num(p3_bnum_ff), .den(p3_bden_ff),
      .quotient(b_quo), .saturated(b_sat)
   );

   cmoc_divider #(.NUM_W(34), .DEN_W(26), .QUO_W(QUOT_W)) u_over_div (
      .clock(clock), .num(p3_onum_ff), .den(p3_oden_ff),
      .quotient(o_quo), .saturated(o_sat)
   );

   cmoc_divider #(.NUM_W(39), .DEN_W(24), .QUO_W(QUOT_W)) u_alpha_div (
      .clock(clock), .num(p3_anum_ff), .den(p3_aden_ff),
      .quotient(a_quo), .saturated(a_sat)
   );

   side_type side_ff  [DIV_LAT];
   logic     side_vld_ff [DIV_LAT];

   always_ff @(posedge clock) begin
      side_ff[0] <= p3_side_ff;
      if (reset) begin
         side_vld_ff[0] <= 1'b0;
      end else begin
         side_vld_ff[0] <= p3_valid_ff;
      end
   end

   for (genvar i = 1; i < DIV_LAT; i++) begin : g_side
      always_ff @(posedge clock) begin
         side_ff[i] <= side_ff[i-1];
         if (reset) begin
            side_vld_ff[i] <= 1'b0;
         end else begin
            side_vld_ff[i] <= side_vld_ff[i-1];
         end
      end
   end

   // ------------------------------------------------------------------
   // Index and alpha resolution, palette memory access.
   // ------------------------------------------------------------------
   side_type           sd;
   logic               sd_valid;
   logic [7:0]         bidx, oidx;
   logic signed [15:0] a_sum;
   logic [12:0]        a_final;
   logic               is_pixel, bg_we, over_we, pal_in_range;
   logic [PAL_AW-1:0]  pal_waddr, bg_raddr, over_raddr;

   assign sd       = side_ff[DIV_LAT-1];
   assign sd_valid = side_vld_ff[DIV_LAT-1];

   always_comb begin
      if (sd.b_lo) begin
         bidx = 8'd0;
      end else if (sd.b_hi || b_sat || (b_quo > QUOT_W'(COLOR_MAX))) begin
         bidx = COLOR_MAX;
      end else begin
         bidx = b_quo[7:0];
      end

      // An empty overlay window picks an end of the palette instead of dividing.
      if (sd.o_empty) begin
         oidx = sd.ov_gt_olo ? COLOR_MAX : 8'd0;
      end else if (sd.o_neg) begin
         oidx = 8'd0;
      end else if (o_sat || (o_quo > QUOT_W'(COLOR_MAX))) begin
         oidx = COLOR_MAX;
      end else begin
         oidx = o_quo[7:0];
      end

      // Below the knee, or with a zero knee span, alpha is alpha_high, clipped to ALPHA_ONE.
      if (sd.a_const) begin
         a_sum = 16'(sd.a_high);
      end else if (a_sat) begin
         a_sum = sd.a_negq ? -16'sd1 : 16'(ALPHA_ONE);
      end else if (sd.a_negq) begin
         a_sum = 16'(sd.a_high) - 16'(a_quo);
      end else begin
         a_sum = 16'(sd.a_high) + 16'(a_quo);
      end
      if (a_sum < 0) begin
         a_final = 13'd0;
      end else if (a_sum > 16'(ALPHA_ONE)) begin
         a_final = ALPHA_ONE;
      end else begin
         a_final = a_sum[12:0];
      end
   end

   assign is_pixel     = sd_valid && (sd.func == FUNC_PIXEL);
   assign pal_in_range = 32'(sd.pal_index) < PALETTE_DEPTH;
   assign bg_we        = sd_valid && (sd.func == FUNC_BG_LOAD) && pal_in_range;
   assign over_we      = sd_valid && (sd.func == FUNC_OVER_LOAD) && pal_in_range;
   assign pal_waddr    = PAL_AW'(sd.pal_index);
   assign bg_raddr     = PAL_AW'(bidx);
   assign over_raddr   = PAL_AW'(oidx);

   logic [23:0] bg_pal_mem   [PALETTE_DEPTH];
   logic [23:0] over_pal_mem [PALETTE_DEPTH];
   logic [23:0] bg_rd_ff, over_rd_ff;

   always_ff @(posedge clock) begin
      if (bg_we) begin
         bg_pal_mem[pal_waddr] <= sd.pal_rgb;
      end
      bg_rd_ff <= bg_pal_mem[bg_raddr];
   end

   always_ff @(posedge clock) begin
      if (over_we) begin
         over_pal_mem[pal_waddr] <= sd.pal_rgb;
      end
      over_rd_ff <= over_pal_mem[over_raddr];
   end

   logic        p5_valid_ff, p5_shown_ff, p5_blend_ff, p5_bmiss_ff, p5_omiss_ff;
   logic [12:0] p5_alpha_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p5_valid_ff <= 1'b0;
      end else begin
         p5_valid_ff <= is_pixel;
      end
      p5_shown_ff <= sd.shown;
      p5_blend_ff <= sd.blend;
      p5_alpha_ff <= a_final;
      // Indexes past the palette read as black.
      p5_bmiss_ff <= 32'(bidx) >= PALETTE_DEPTH;
      p5_omiss_ff <= 32'(oidx) >= PALETTE_DEPTH;
   end

   // ------------------------------------------------------------------
   // Blend multiply, then sum and select into the response queue.
   // ------------------------------------------------------------------
   logic [23:0] p5_bcol, p5_ocol;
   logic [12:0] p5_beta;

   assign p5_bcol = p5_bmiss_ff ? 24'd0 : bg_rd_ff;
   assign p5_ocol = p5_omiss_ff ? 24'd0 : over_rd_ff;
   assign p5_beta = ALPHA_ONE - p5_alpha_ff;

   logic        p6_valid_ff, p6_shown_ff, p6_blend_ff;
   logic [23:0] p6_bcol_ff, p6_ocol_ff;
   logic [20:0] p6_bprod_ff [3];
   logic [20:0] p6_oprod_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         p6_valid_ff <= 1'b0;
      end else begin
         p6_valid_ff <= p5_valid_ff;
      end
      p6_shown_ff <= p5_shown_ff;
      p6_blend_ff <= p5_blend_ff;
      p6_bcol_ff  <= p5_bcol;
      p6_ocol_ff  <= p5_ocol;
   end

   for (genvar c = 0; c < 3; c++) begin : g_mul
      always_ff @(posedge clock) begin
         p6_bprod_ff[c] <= 21'(p5_beta) * 21'(p5_bcol[8*c +: 8]);
         p6_oprod_ff[c] <= 21'(p5_alpha_ff) * 21'(p5_ocol[8*c +: 8]);
      end
   end

   logic [23:0]  mix_col, res_col;
   logic [21:0]  mix_sum [3];
   rsp_word_type push_word;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         mix_sum[c] = 22'(p6_bprod_ff[c]) + 22'(p6_oprod_ff[c]);
         mix_col[8*c +: 8] = (mix_sum[c][21:12] > 10'(COLOR_MAX)) ? COLOR_MAX
                                                                  : mix_sum[c][19:12];
      end
      if (!p6_shown_ff) begin
         res_col = p6_bcol_ff;
      end else if (p6_blend_ff) begin
         res_col = mix_col;
      end else begin
         res_col = p6_ocol_ff;
      end
      push_word.red           = res_col[23:16];
      push_word.green         = res_col[15:8];
      push_word.blue          = res_col[7:0];
      push_word.overlay_shown = p6_shown_ff;
   end

   // Response queue.
   rsp_word_type         fifo_ff [RSP_FIFO_DEPTH];
   logic [RSP_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [RSP_CNT_W-1:0] fifo_cnt_ff;

   always_ff @(posedge clock) begin
      if (p6_valid_ff) begin
         fifo_ff[wr_ptr_ff] <= push_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         fifo_cnt_ff <= '0;
      end else begin
         if (p6_valid_ff) begin
            wr_ptr_ff <= wr_ptr_ff + RSP_PTR_W'(1);
         end
         if (rsp_pop) begin
            rd_ptr_ff <= rd_ptr_ff + RSP_PTR_W'(1);
         end
         if (p6_valid_ff && !rsp_pop) begin
            fifo_cnt_ff <= fifo_cnt_ff + RSP_CNT_W'(1);
         end else if (!p6_valid_ff && rsp_pop) begin
            fifo_cnt_ff <= fifo_cnt_ff - RSP_CNT_W'(1);
         end
      end
   end

   assign rsp_valid = fifo_cnt_ff != '0;
   assign rsp_data  = fifo_ff[rd_ptr_ff];

   // ------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------
`include "assert_macros.svh"

   `ASSERT_CLK(a_credit_bound, clock, reset, credit_ff <= RSP_CNT_W'(RSP_FIFO_DEPTH), "credit count exceeds the response queue depth")
   `ASSERT_CLK(a_queue_within_credit, clock, reset, fifo_cnt_ff <= credit_ff, "queued responses exceed outstanding pixels")
   `ASSERT_CLK(a_no_overflow, clock, reset, (p6_valid_ff && !rsp_pop) |-> (fifo_cnt_ff != RSP_CNT_W'(RSP_FIFO_DEPTH)), "push into a full response queue")

endmodule

// ===== tb/colormap_overlay_compositor_checker.sv =====
`timescale 1ns / 1ps
module colormap_overlay_compositor_checker
   import cmoc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_ready,
   input  req_word_type req_data,
   input  logic         rsp_valid,
   input  logic         rsp_ready,
   input  rsp_word_type rsp_data,
   input  logic         csr_valid,
   input  logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [23:0]  csr_wdata,
   output int           mismatches,
   output int           pending
);

   // Handshakes are sampled at the falling edge; inputs only change at the rising
   // edge, so these values are the ones the block sees at the next rising edge.
   logic [2:0]         mode_q;
   logic signed [23:0] bg_low_q, bg_high_q, over_low_q, over_high_q, knee_q;
   logic [12:0]        alpha_low_q, alpha_high_q;
   logic [23:0]        bg_colors [256];
   logic [23:0]        over_colors [256];
   rsp_word_type       pixel_colors [$];

   assign pending = pixel_colors.size();

   function automatic longint floor_quot(input longint n, input longint d);
      longint q;
      q = n / d;
      if ((n % d) != 0 && n < 0) q--;
      return q;
   endfunction

   function automatic longint clip(input longint x, input longint lo, input longint hi);
      return x < lo ? lo : (x > hi ? hi : x);
   endfunction

   function automatic rsp_word_type composite(input longint bv, input longint ov);
      longint blo, bhi, olo, ohi, knee, bidx, oidx, span, n, d, a, num, den, bc, oc, c;
      logic [23:0] bcol, ocol, res;
      logic [2:0]  kind;
      logic        blend, shown;
      rsp_word_type w;
      blo = bg_low_q; bhi = bg_high_q; olo = over_low_q; ohi = over_high_q; knee = knee_q;
      if (bv <= blo) bidx = 0;
      else if (bv >= bhi) bidx = 255;
      else begin
         span = bhi - blo;
         bidx = clip(floor_quot(2 * (bv - blo) * 255 + span, 2 * span), 0, 255);
      end
      bcol = bg_colors[bidx];
      d = ohi - olo;
      if (d == 0) oidx = ov > olo ? 255 : 0;
      else begin
         n = (ov - olo) * 255;
         if (d < 0) begin
            n = -n;
            d = -d;
         end
         oidx = clip(floor_quot(2 * n + d, 2 * d), 0, 255);
      end
      ocol = over_colors[oidx];
      blend = mode_q >= MODE_BLEND_BASE;
      kind = blend ? mode_q - MODE_BLEND_BASE : mode_q;
      if (kind == KIND_ABOVE) shown = ov >= olo;
      else if (kind == KIND_BELOW) shown = ov <= ohi;
      else shown = ov >= olo && ov <= ohi;
      res = bcol;
      if (shown && !blend) res = ocol;
      else if (shown) begin
         den = knee - ohi;
         if (ov < knee || den == 0) a = alpha_high_q;
         else begin
            num = (longint'(alpha_high_q) - longint'(alpha_low_q)) * (ov - knee);
            if (den < 0) begin
               num = -num;
               den = -den;
            end
            a = longint'(alpha_high_q) + floor_quot(num, den);
         end
         a = clip(a, 0, ALPHA_ONE);
         for (int sh = 16; sh >= 0; sh -= 8) begin
            bc = (bcol >> sh) & 8'hFF;
            oc = (ocol >> sh) & 8'hFF;
            c = clip(((ALPHA_ONE - a) * bc + a * oc) >>> 12, 0, COLOR_MAX);
            res[sh +: 8] = c[7:0];
         end
      end
      w.red = res[23:16];
      w.green = res[15:8];
      w.blue = res[7:0];
      w.overlay_shown = shown;
      return w;
   endfunction

   task automatic report(input string field, input int got, input int want);
      $display("mismatch at %0t: %s got %0d expected %0d", $time, field, got, want);
      mismatches++;
   endtask

   initial mismatches = 0;

   always @(negedge clock) begin
      rsp_word_type want;
      if (reset) begin
         mode_q = RST_MODE;
         bg_low_q = RST_BG_LOW;
         bg_high_q = RST_BG_HIGH;
         over_low_q = RST_OVER_LOW;
         over_high_q = RST_OVER_HIGH;
         alpha_low_q = RST_ALPHA_LOW;
         alpha_high_q = RST_ALPHA_HIGH;
         knee_q = RST_KNEE;
         pixel_colors.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pixel_colors.size() == 0) report("unexpected word", 1, 0);
            else begin
               want = pixel_colors.pop_front();
               if (rsp_data.red != want.red) report("red", rsp_data.red, want.red);
               if (rsp_data.green != want.green) report("green", rsp_data.green, want.green);
               if (rsp_data.blue != want.blue) report("blue", rsp_data.blue, want.blue);
               if (rsp_data.overlay_shown != want.overlay_shown)
                  report("overlay_shown", rsp_data.overlay_shown, want.overlay_shown);
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_MODE:       mode_q = csr_wdata[2:0];
               REG_BG_LOW:     bg_low_q = csr_wdata;
               REG_BG_HIGH:    bg_high_q = csr_wdata;
               REG_OVER_LOW:   over_low_q = csr_wdata;
               REG_OVER_HIGH:  over_high_q = csr_wdata;
               REG_ALPHA_LOW:  alpha_low_q = csr_wdata[12:0];
               REG_ALPHA_HIGH: alpha_high_q = csr_wdata[12:0];
               REG_ALPHA_KNEE: knee_q = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            case (req_data.func)
               FUNC_PIXEL: pixel_colors.push_back(composite($signed(req_data.bg_value),
                                                            $signed(req_data.over_value)));
               FUNC_BG_LOAD: bg_colors[req_data.palette_index] = {req_data.palette_red,
                  req_data.palette_green, req_data.palette_blue};
               FUNC_OVER_LOAD: over_colors[req_data.palette_index] = {req_data.palette_red,
                  req_data.palette_green, req_data.palette_blue};
               default: ;
            endcase
         end
      end
   end

endmodule

// ===== tb/colormap_overlay_compositor_tb.sv =====
`timescale 1ns / 1ps
// Top of the compositor testbench. It makes the stimulus and gives the verdict;
// the checker beside the block predicts every response word and compares it.
module colormap_overlay_compositor_tb;
   import cmoc_pkg::*;

   localparam int RANDOM_WORDS = 1325;
   localparam int CYCLE_LIMIT  = 600000;
   // A palette load can still be in flight when the last response has arrived, so
   // configuration also waits DRAIN_CYCLES after that.
   localparam int DRAIN_CYCLES = 40;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   req_word_type req_data;
   logic         rsp_valid;
   logic         rsp_ready;
   rsp_word_type rsp_data;
   logic         csr_valid;
   logic         csr_ready;
   logic [2:0]   csr_index;
   logic [23:0]  csr_wdata;
   int           mismatches;
   int           pending;
   int           cycle_count;
   // The sender's burst state. req_on mirrors req_valid so that a step never
   // carries two assignments to it.
   bit           req_on;
   int           burst_left;
   // Current window edges, kept so that samples can be aimed near them.
   logic signed [23:0] cur_bg_low, cur_bg_high, cur_over_low, cur_over_high, cur_knee;

   colormap_overlay_compositor dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   colormap_overlay_compositor_checker checker_i (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_wdata(csr_wdata), .mismatches(mismatches), .pending(pending)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // A run that hangs ends here.
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("colormap_overlay_compositor_tb failed");
         $finish;
      end
   end

   // The receiver changes its stall style periodically: always ready, coin
   // flips, a repeating 16-bit pattern, or long stalls with rare ready cycles.
   int          rx_style;
   logic [15:0] rx_pattern;
   always @(posedge clock) begin
      if (cycle_count % 64 == 0) begin
         rx_style <= int'($urandom_range(3));
         rx_pattern <= 16'($urandom);
      end
      case (rx_style)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= 1'($urandom_range(1));
         2: rsp_ready <= rx_pattern[cycle_count % 16];
         default: rsp_ready <= ($urandom_range(7) == 0);
      endcase
   end

   task automatic stop_sending();
      if (req_on) begin
         req_valid <= 1'b0;
         req_on = 1'b0;
      end
   endtask

   // Sends one word and returns at the rising edge that accepted it or, when the word
   // ends a burst, possibly after a random pause with req_valid low. Ready is looked
   // at on the falling edge, where it already holds its value for the next rising edge.
   task automatic send_word(input req_word_type w);
      bit taken;
      req_valid <= 1'b1;
      req_data <= w;
      req_on = 1'b1;
      do begin
         @(negedge clock);
         taken = req_ready;
         @(posedge clock);
      end while (!taken);
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = int'($urandom_range(1, 40));
         if ($urandom_range(3) != 0) begin
            stop_sending();
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
   endtask

   task automatic wait_idle();
      stop_sending();
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [23:0] value);
      bit taken;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do begin
         @(negedge clock);
         taken = csr_ready;
         @(posedge clock);
      end while (!taken);
   endtask

   task automatic configure(input logic [2:0] mode, input logic signed [23:0] bl,
                            input logic signed [23:0] bh, input logic signed [23:0] ol,
                            input logic signed [23:0] oh, input logic [12:0] al,
                            input logic [12:0] ah, input logic signed [23:0] kn);
      wait_idle();
      csr_write(REG_MODE, {21'd0, mode});
      csr_write(REG_BG_LOW, bl);
      csr_write(REG_BG_HIGH, bh);
      csr_write(REG_OVER_LOW, ol);
      csr_write(REG_OVER_HIGH, oh);
      csr_write(REG_ALPHA_LOW, {11'd0, al});
      csr_write(REG_ALPHA_HIGH, {11'd0, ah});
      csr_write(REG_ALPHA_KNEE, kn);
      csr_valid <= 1'b0;
      cur_bg_low = bl;
      cur_bg_high = bh;
      cur_over_low = ol;
      cur_over_high = oh;
      cur_knee = kn;
   endtask

   // A sample mostly close to the span between window edges a and b, sometimes exactly on
   // one of them and sometimes anywhere in the 24-bit range.
   function automatic logic signed [23:0] sample_near(input logic signed [23:0] a,
                                                       input logic signed [23:0] b);
      longint lo, hi;
      int pick;
      pick = int'($urandom_range(9));
      if (pick < 2) return 24'($urandom);
      if (pick == 2) return a;
      if (pick == 3) return b;
      lo = a < b ? a : b;
      hi = a < b ? b : a;
      lo = lo - 300;
      hi = hi + 300;
      if (lo < -8388608) lo = -8388608;
      if (hi > 8388607) hi = 8388607;
      return 24'(lo + longint'($urandom_range(int'(hi - lo), 0)));
   endfunction

   function automatic logic signed [23:0] rand_edge();
      if ($urandom_range(2) == 0) return 24'($urandom);
      return $signed(24'($urandom_range(16384))) - 24'sd8192;
   endfunction

   function automatic req_word_type pixel_word(input logic signed [23:0] bv,
                                              input logic signed [23:0] ov);
      req_word_type w;
      w.func = FUNC_PIXEL;
      w.bg_value = bv;
      w.over_value = ov;
      w.palette_index = 8'($urandom);
      w.palette_red = 8'($urandom);
      w.palette_green = 8'($urandom);
      w.palette_blue = 8'($urandom);
      return w;
   endfunction

   function automatic req_word_type load_word(input logic [1:0] f, input logic [7:0] idx);
      req_word_type w;
      w.func = f;
      w.bg_value = 24'($urandom);
      w.over_value = 24'($urandom);
      w.palette_index = idx;
      w.palette_red = 8'($urandom);
      w.palette_green = 8'($urandom);
      w.palette_blue = 8'($urandom);
      return w;
   endfunction

   task automatic random_phase(input int count);
      int sent;
      int pick;
      logic signed [23:0] ov;
      sent = 0;
      while (sent < count) begin
         pick = int'($urandom_range(99));
         if (pick < 6) begin
            send_word(load_word(FUNC_BG_LOAD, 8'($urandom)));
            sent++;
         end else if (pick < 12) begin
            send_word(load_word(FUNC_OVER_LOAD, 8'($urandom)));
            sent++;
         end else if (pick < 14) begin
            // An unused item kind is dropped by the block and not counted.
            send_word(load_word(2'd3, 8'($urandom)));
         end else begin
            ov = ($urandom_range(3) == 0) ? sample_near(cur_knee, cur_over_high)
                                          : sample_near(cur_over_low, cur_over_high);
            send_word(pixel_word(sample_near(cur_bg_low, cur_bg_high), ov));
            sent++;
         end
         // Halfway through, the sender sometimes holds off until every response has arrived.
         if (sent == count / 2 && $urandom_range(1) == 0) begin
            stop_sending();
            do @(posedge clock); while (pending != 0);
         end
      end
   endtask

   initial begin
      req_valid <= 1'b0;
      req_data <= '0;
      csr_valid <= 1'b0;
      csr_index <= REG_MODE;
      csr_wdata <= '0;
      rsp_ready <= 1'b0;
      rx_style = 0;
      rx_pattern = 16'hFFFF;
      req_on = 1'b0;
      burst_left = 20;
      cur_bg_low = RST_BG_LOW;
      cur_bg_high = RST_BG_HIGH;
      cur_over_low = RST_OVER_LOW;
      cur_over_high = RST_OVER_HIGH;
      cur_knee = RST_KNEE;
      reset = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Every palette entry is loaded first, so no pixel ever reads an entry
      // that was never written.
      for (int i = 0; i < 256; i++) begin
         send_word(load_word(FUNC_BG_LOAD, 8'(i)));
         send_word(load_word(FUNC_OVER_LOAD, 8'(i)));
      end

      // Directed words under the reset settings: the extremes of both samples,
      // the window and band edges, an unused item kind and two palette loads.
      send_word(pixel_word(24'sh800000, 24'sh800000));
      send_word(pixel_word(24'sh7FFFFF, 24'sh7FFFFF));
      send_word(pixel_word(RST_BG_LOW, RST_OVER_LOW));
      send_word(pixel_word(RST_BG_HIGH, RST_OVER_HIGH));
      send_word(pixel_word(RST_BG_LOW + 24'sd1, RST_OVER_LOW - 24'sd1));
      send_word(pixel_word(RST_BG_HIGH - 24'sd1, RST_OVER_HIGH + 24'sd1));
      send_word(pixel_word(24'sd522240, 24'sd1024));
      send_word(pixel_word(24'sd2048, 24'sd4));
      send_word(pixel_word(24'shFFFFFF, 24'sh555555));
      send_word(pixel_word(24'sh555555, 24'shAAAAAA));
      send_word(load_word(2'd3, 8'hFF));
      send_word(load_word(FUNC_BG_LOAD, 8'd0));
      send_word(load_word(FUNC_OVER_LOAD, 8'd255));
      send_word(pixel_word(24'sd0, 24'sd4096));

      // Phases of settings: reset-like values, every mode including the unused
      // ones, full-range and empty or inverted windows, a zero knee span,
      // and alpha at and beyond its extremes.
      configure(3'd3, 24'sd0, 24'sd1044480, 24'sd0, 24'sd2048, 13'd0, 13'd4096, 24'sd1024);
      random_phase(RANDOM_WORDS / 10);
      configure(3'd4, 24'sh800000, 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF,
                13'd4096, 13'd0, 24'sd0);
      random_phase(RANDOM_WORDS / 10);
      configure(3'd5, 24'sd500, 24'sd500, 24'sd300, 24'sd300, 13'd1000, 13'd3000, 24'sd300);
      random_phase(RANDOM_WORDS / 10);
      configure(3'd1, 24'sd4000, -24'sd4000, 24'sd5000, -24'sd5000,
                13'd8191, 13'd8191, 24'sd0);
      random_phase(RANDOM_WORDS / 10);
      configure(3'd2, -24'sd100, 24'sd100, -24'sd2048, 24'sd2048, 13'd0, 13'd0, -24'sd4096);
      random_phase(RANDOM_WORDS / 10);
      configure(3'd6, -24'sd8192, 24'sd8192, 24'sd100, 24'sd9000, 13'd200, 13'd4096, 24'sd8000);
      random_phase(RANDOM_WORDS / 10);
      configure(3'd7, 24'sd0, 24'sd4096, -24'sd3000, 24'sd3000, 13'd4096, 13'd100, 24'sd5000);
      random_phase(RANDOM_WORDS / 10);
      for (int p = 0; p < 3; p++) begin
         configure(3'($urandom), rand_edge(), rand_edge(), rand_edge(), rand_edge(),
                   13'($urandom_range(4096)), 13'($urandom_range(4096)), rand_edge());
         random_phase(RANDOM_WORDS / 10);
      end
      configure(RST_MODE, RST_BG_LOW, RST_BG_HIGH, RST_OVER_LOW, RST_OVER_HIGH,
                RST_ALPHA_LOW, RST_ALPHA_HIGH, RST_KNEE);
      random_phase(RANDOM_WORDS - 10 * (RANDOM_WORDS / 10));

      stop_sending();
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("colormap_overlay_compositor_tb passed");
      end else begin
         $display("colormap_overlay_compositor_tb failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/cmoc_pkg.sv
rtl/core/cmoc_divider.sv
rtl/core/colormap_overlay_compositor.sv
tb/colormap_overlay_compositor_checker.sv
tb/colormap_overlay_compositor_tb.sv
